FILE: design/pngcp_pkg.sv
// pngcp_pkg: shared types, role codes and constant tables of the PNG chunk parser.
// Holds the signature bytes, chunk type words and the injected hiVe chunk with its CRC.
// No dependencies.
`timescale 1ns / 1ps

package pngcp_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [2:0] ROLE_SIG  = 3'd0;
  localparam logic [2:0] ROLE_LEN  = 3'd1;
  localparam logic [2:0] ROLE_TYPE = 3'd2;
  localparam logic [2:0] ROLE_DATA = 3'd3;
  localparam logic [2:0] ROLE_CRC  = 3'd4;
  localparam logic [2:0] ROLE_INJ  = 3'd5;
  localparam logic [2:0] ROLE_DROP = 3'd6;

  localparam logic [31:0] TYPE_IEND = 32'h444E4549;
  localparam logic [31:0] TYPE_IHDR = 32'h52444849;
  localparam logic [31:0] TYPE_TEXT = 32'h74584574;
  localparam logic [31:0] TYPE_HIVE = 32'h65566968;

  localparam logic [7:0] SIG_BYTES [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};

  localparam int INJ_LEN = 25;
  localparam logic [4:0] INJ_LAST      = 5'd24;
  localparam logic [4:0] INJ_TEXT_LO   = 5'd8;
  localparam logic [4:0] INJ_TEXT_HI   = 5'd20;

  // type "hiVe" then data "Hello, world!"
  localparam logic [7:0] INJ_BODY [17] = '{8'h68, 8'h69, 8'h56, 8'h65,
                                           8'h48, 8'h65, 8'h6C, 8'h6C, 8'h6F,
                                           8'h2C, 8'h20, 8'h77, 8'h6F, 8'h72,
                                           8'h6C, 8'h64, 8'h21};

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] role;
    logic       text;
    logic       chunk_done;
    logic       stream_done;
    logic       sig_error;
    logic       inject;
  } pngcp_rec_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] role;
    logic       text;
    logic       chunk_done;
    logic       stream_done;
    logic       sig_error;
    logic       last;
  } pngcp_res_t;

  function automatic logic [31:0] inj_crc_calc();
    logic [31:0] c;
    c = 32'hFFFFFFFF;
    for (int i = 0; i < 17; i++) begin
      c = c ^ {24'd0, INJ_BODY[i]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
      end
    end
    return c ^ 32'hFFFFFFFF;
  endfunction

  localparam logic [31:0] INJ_CRC = inj_crc_calc();

  function automatic logic [7:0] inj_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx) inside
      5'd3:          b = 8'd13;
      [5'd4:5'd20]:  b = INJ_BODY[5'(idx - 5'd4)];
      5'd21:         b = INJ_CRC[31:24];
      5'd22:         b = INJ_CRC[23:16];
      5'd23:         b = INJ_CRC[15:8];
      5'd24:         b = INJ_CRC[7:0];
      default:       b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: design/pngcp_front.sv
// pngcp_front: accepts input bytes, tracks signature and chunk framing, tags each byte.
// Writes one classified request per accepted byte into the queue; uses pngcp_pkg.
`timescale 1ns / 1ps

module pngcp_front import pngcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  output logic       full,
  input  logic       inject_enable_we,
  input  logic       inject_enable,
  input  logic       q_full,
  output logic       q_wr,
  output pngcp_rec_t q_rec
);

  typedef enum logic [6:0] {
    PH_SIG  = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_TYPE = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_CRC  = 7'b0010000,
    PH_DONE = 7'b0100000,
    PH_ERR  = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  field_idx, field_idx_next;
  logic [2:0]  sig_idx, sig_idx_next;
  logic [31:0] frame_len, frame_len_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] type_word, type_word_next;
  logic        inj_en;
  logic        accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept;

  always_comb begin
    phase_next     = phase;
    field_idx_next = field_idx;
    sig_idx_next   = sig_idx;
    frame_len_next = frame_len;
    remaining_next = remaining;
    type_word_next = type_word;
    q_rec             = '0;
    q_rec.data        = in_byte;
    unique case (phase)
      PH_SIG: begin
        if (in_byte == SIG_BYTES[sig_idx]) begin
          q_rec.role = ROLE_SIG;
          if (sig_idx == 3'd7) begin
            sig_idx_next   = 3'd0;
            field_idx_next = 2'd0;
            phase_next     = PH_LEN;
          end else begin
            sig_idx_next = sig_idx + 3'd1;
          end
        end else begin
          phase_next      = PH_ERR;
          q_rec.role      = ROLE_DROP;
          q_rec.sig_error = 1'b1;
        end
      end
      PH_LEN: begin
        frame_len_next = {frame_len[23:0], in_byte};
        q_rec.role     = ROLE_LEN;
        if (field_idx == 2'd3) begin
          field_idx_next = 2'd0;
          phase_next     = PH_TYPE;
        end else begin
          field_idx_next = field_idx + 2'd1;
        end
      end
      PH_TYPE: begin
        type_word_next = {in_byte, type_word[31:8]};
        q_rec.role     = ROLE_TYPE;
        if (field_idx == 2'd3) begin
          field_idx_next = 2'd0;
          remaining_next = frame_len;
          phase_next     = (frame_len != 32'd0) ? PH_DATA : PH_CRC;
        end else begin
          field_idx_next = field_idx + 2'd1;
        end
      end
      PH_DATA: begin
        q_rec.role     = ROLE_DATA;
        q_rec.text     = (type_word == TYPE_TEXT) || (type_word == TYPE_HIVE);
        remaining_next = remaining - 32'd1;
        if (remaining == 32'd1) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        q_rec.role = ROLE_CRC;
        if (field_idx == 2'd3) begin
          field_idx_next   = 2'd0;
          q_rec.chunk_done = 1'b1;
          if (type_word == TYPE_IEND) begin
            phase_next        = PH_DONE;
            q_rec.stream_done = 1'b1;
          end else begin
            phase_next   = PH_LEN;
            q_rec.inject = (type_word == TYPE_IHDR) && inj_en;
          end
        end else begin
          field_idx_next = field_idx + 2'd1;
        end
      end
      PH_DONE: begin
        q_rec.role        = ROLE_DROP;
        q_rec.stream_done = 1'b1;
      end
      PH_ERR: begin
        q_rec.role      = ROLE_DROP;
        q_rec.sig_error = 1'b1;
      end
      default: begin
        phase_next      = PH_ERR;
        q_rec.role      = ROLE_DROP;
        q_rec.sig_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SIG;
      field_idx <= 2'd0;
      sig_idx   <= 3'd0;
      frame_len <= 32'd0;
      remaining <= 32'd0;
      type_word <= 32'd0;
      inj_en    <= 1'b0;
    end else begin
      if (inject_enable_we) begin
        inj_en <= inject_enable;
      end
      if (accept) begin
        phase     <= phase_next;
        field_idx <= field_idx_next;
        sig_idx   <= sig_idx_next;
        frame_len <= frame_len_next;
        remaining <= remaining_next;
        type_word <= type_word_next;
      end
    end
  end

endmodule

FILE: design/pngcp_fifo.sv
// pngcp_fifo: short queue of classified requests between front and back.
// Register file with read and write pointers; uses pngcp_pkg.
`timescale 1ns / 1ps

module pngcp_fifo import pngcp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  pngcp_rec_t       wr_rec,
  input  logic             rd,
  output pngcp_rec_t       rd_rec,
  output logic             q_full,
  output logic             q_empty,
  output logic [FIFO_AW:0] count
);

  pngcp_rec_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr, rptr;
  logic                 do_wr, do_rd;

  assign q_full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_rec  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (do_rd) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + (FIFO_AW+1)'(1);
        2'b01:   count <= count - (FIFO_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/pngcp_back.sv
// pngcp_back: drains queued requests into the result register and plays out the hiVe chunk.
// Uses pngcp_pkg for the result struct and the injected byte table.
`timescale 1ns / 1ps

module pngcp_back import pngcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  pngcp_rec_t q_rec,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output pngcp_res_t res
);

  logic       out_valid, out_valid_next;
  logic       inj_active, inj_active_next;
  logic [4:0] inj_idx, inj_idx_next;
  logic       load;
  pngcp_res_t res_next;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;

  always_comb begin
    out_valid_next  = out_valid;
    inj_active_next = inj_active;
    inj_idx_next    = inj_idx;
    res_next        = res;
    q_rd            = 1'b0;
    if (load) begin
      if (inj_active) begin
        out_valid_next = 1'b1;
        res_next       = '0;
        res_next.data  = inj_byte(inj_idx);
        res_next.role  = ROLE_INJ;
        res_next.text  = (inj_idx >= INJ_TEXT_LO) && (inj_idx <= INJ_TEXT_HI);
        res_next.last  = (inj_idx == INJ_LAST);
        if (inj_idx == INJ_LAST) begin
          inj_active_next = 1'b0;
        end else begin
          inj_idx_next = inj_idx + 5'd1;
        end
      end else if (!q_empty) begin
        q_rd                 = 1'b1;
        out_valid_next       = 1'b1;
        res_next.data        = q_rec.data;
        res_next.role        = q_rec.role;
        res_next.text        = q_rec.text;
        res_next.chunk_done  = q_rec.chunk_done;
        res_next.stream_done = q_rec.stream_done;
        res_next.sig_error   = q_rec.sig_error;
        res_next.last        = !q_rec.inject;
        inj_active_next      = q_rec.inject;
        inj_idx_next         = 5'd0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      inj_active <= 1'b0;
      inj_idx    <= 5'd0;
    end else begin
      out_valid  <= out_valid_next;
      inj_active <= inj_active_next;
      inj_idx    <= inj_idx_next;
    end
  end

endmodule

FILE: design/png_chunk_stream_parser.sv
// Top level of the PNG chunk stream parser: front classifier, request queue, result back end.
// Depends on pngcp_pkg, pngcp_front, pngcp_fifo and pngcp_back.
`timescale 1ns / 1ps

// Takes one PNG byte per cycle while full is low and gives one tagged result per byte,
// one per cycle while pop is held; each byte passes the request queue and the result
// register. The last CRC byte of an IHDR chunk, with inject_enable set, is followed by
// 25 injected results, which hold the result port; meanwhile the front keeps taking
// bytes until the 4-entry request queue is full. Framing is decided in the front in the
// cycle a byte is taken; the result register on the output side sets the rate.
// inject_enable is written through inject_enable_we and applies from the next byte.

module png_chunk_stream_parser import pngcp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       inject_enable_we,
  input  logic       inject_enable,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [2:0] byte_role,
  output logic       text_data,
  output logic       chunk_done,
  output logic       stream_done,
  output logic       sig_error,
  output logic       last
);

  logic             q_wr, q_rd, q_full, q_empty;
  logic [FIFO_AW:0] q_count;
  pngcp_rec_t       wr_rec, rd_rec;
  pngcp_res_t       res;

  pngcp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .in_byte          (in_byte),
    .full             (full),
    .inject_enable_we (inject_enable_we),
    .inject_enable    (inject_enable),
    .q_full           (q_full),
    .q_wr             (q_wr),
    .q_rec            (wr_rec)
  );

  pngcp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_rec  (wr_rec),
    .rd      (q_rd),
    .rd_rec  (rd_rec),
    .q_full  (q_full),
    .q_empty (q_empty),
    .count   (q_count)
  );

  pngcp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rec   (rd_rec),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_byte    = res.data;
  assign byte_role   = res.role;
  assign text_data   = res.text;
  assign chunk_done  = res.chunk_done;
  assign stream_done = res.stream_done;
  assign sig_error   = res.sig_error;
  assign last        = res.last;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("request queue overfilled");

  a_injection_unbroken: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> !empty)
    else $error("gap inside an injected chunk");

  a_error_dropped: assert property (@(posedge clk) disable iff (rst)
    (!empty && sig_error) |-> (byte_role == ROLE_DROP))
    else $error("byte after signature error not dropped");

endmodule

FILE: verif/png_chunk_stream_parser_tb.sv
// Self-checking testbench of png_chunk_stream_parser: drives one PNG byte stream of random
// chunks with hiVe insertion toggled between them, or a bad signature and random bytes, and
// checks every tagged byte in order. Depends on pngcp_pkg and png_chunk_stream_parser RTL.
`timescale 1ns / 1ps

module png_chunk_stream_parser_tb;
  import pngcp_pkg::*;

  localparam logic [31:0] TYPE_IDAT = 32'h54414449;
  localparam logic [31:0] TYPE_PLTE = 32'h45544C50;

  typedef enum logic [2:0] {
    PS_SIGN, PS_LEN, PS_TYPE, PS_DATA, PS_CRC, PS_DONE, PS_ERR
  } parse_state_e;

  class png_tag_scoreboard;
    pngcp_res_t   tags_due[$];
    bit           inject_on;
    parse_state_e state;
    logic [1:0]   field_idx;
    logic [2:0]   sig_idx;
    logic [31:0]  frame_len;
    logic [31:0]  data_left;
    logic [31:0]  type_word;
    logic [7:0]   hive_chunk[INJ_LEN];
    int           errors;
    int           checked;
    int           insertions;

    function new();
      string       body;
      logic [31:0] crc;
      body = "hiVeHello, world!";
      inject_on = 0;
      state = PS_SIGN;
      field_idx = 0;
      sig_idx = 0;
      frame_len = 0;
      data_left = 0;
      type_word = 0;
      errors = 0;
      checked = 0;
      insertions = 0;
      crc = 32'hFFFFFFFF;
      for (int i = 0; i < 17; i++) begin
        crc = crc ^ {24'd0, 8'(body[i])};
        for (int k = 0; k < 8; k++) begin
          crc = crc[0] ? (32'hEDB88320 ^ (crc >> 1)) : (crc >> 1);
        end
      end
      crc = ~crc;
      hive_chunk[0] = 8'd0;
      hive_chunk[1] = 8'd0;
      hive_chunk[2] = 8'd0;
      hive_chunk[3] = 8'd13;
      for (int i = 0; i < 17; i++) begin
        hive_chunk[4 + i] = 8'(body[i]);
      end
      hive_chunk[21] = crc[31:24];
      hive_chunk[22] = crc[23:16];
      hive_chunk[23] = crc[15:8];
      hive_chunk[24] = crc[7:0];
    endfunction

    function void add_tag(logic [7:0] b, logic [2:0] role, bit text, bit cdone, bit sdone,
                          bit serr);
      pngcp_res_t t;
      t.data = b;
      t.role = role;
      t.text = text;
      t.chunk_done = cdone;
      t.stream_done = sdone;
      t.sig_error = serr;
      t.last = 1'b0;
      tags_due.push_back(t);
    endfunction

    function void note_byte(logic [7:0] b);
      pngcp_res_t t;
      case (state)
        PS_SIGN: begin
          if (b == SIG_BYTES[sig_idx]) begin
            add_tag(b, ROLE_SIG, 0, 0, 0, 0);
            if (sig_idx == 3'd7) begin
              sig_idx = 0;
              field_idx = 0;
              state = PS_LEN;
            end else begin
              sig_idx++;
            end
          end else begin
            state = PS_ERR;
            add_tag(b, ROLE_DROP, 0, 0, 0, 1);
          end
        end
        PS_LEN: begin
          frame_len = {frame_len[23:0], b};
          add_tag(b, ROLE_LEN, 0, 0, 0, 0);
          if (field_idx == 2'd3) begin
            field_idx = 0;
            state = PS_TYPE;
          end else begin
            field_idx++;
          end
        end
        PS_TYPE: begin
          type_word = {b, type_word[31:8]};
          add_tag(b, ROLE_TYPE, 0, 0, 0, 0);
          if (field_idx == 2'd3) begin
            field_idx = 0;
            data_left = frame_len;
            state = (frame_len != 0) ? PS_DATA : PS_CRC;
          end else begin
            field_idx++;
          end
        end
        PS_DATA: begin
          add_tag(b, ROLE_DATA, (type_word == TYPE_TEXT) || (type_word == TYPE_HIVE), 0, 0, 0);
          data_left--;
          if (data_left == 0) state = PS_CRC;
        end
        PS_CRC: begin
          if (field_idx == 2'd3) begin
            field_idx = 0;
            if (type_word == TYPE_IEND) begin
              state = PS_DONE;
              add_tag(b, ROLE_CRC, 0, 1, 1, 0);
            end else begin
              state = PS_LEN;
              add_tag(b, ROLE_CRC, 0, 1, 0, 0);
              if (type_word == TYPE_IHDR && inject_on) begin
                insertions++;
                for (int i = 0; i < INJ_LEN; i++) begin
                  add_tag(hive_chunk[i], ROLE_INJ, (i >= 8) && (i < 21), 0, 0, 0);
                end
              end
            end
          end else begin
            field_idx++;
            add_tag(b, ROLE_CRC, 0, 0, 0, 0);
          end
        end
        PS_DONE: add_tag(b, ROLE_DROP, 0, 0, 1, 0);
        default: begin
          state = PS_ERR;
          add_tag(b, ROLE_DROP, 0, 0, 0, 1);
        end
      endcase
      t = tags_due[tags_due.size() - 1];
      t.last = 1'b1;
      tags_due[tags_due.size() - 1] = t;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 20) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_tag(pngcp_res_t got);
      pngcp_res_t want;
      if (tags_due.size() == 0) begin
        report($sformatf("unexpected tag byte %02h role %0d", got.data, got.role));
      end else begin
        want = tags_due.pop_front();
        checked++;
        if (got.data !== want.data)
          report($sformatf("tag %0d out_byte %02h, want %02h", checked, got.data, want.data));
        if (got.role !== want.role)
          report($sformatf("tag %0d byte_role %0d, want %0d", checked, got.role, want.role));
        if (got.text !== want.text)
          report($sformatf("tag %0d text_data %b, want %b", checked, got.text, want.text));
        if (got.chunk_done !== want.chunk_done)
          report($sformatf("tag %0d chunk_done %b, want %b", checked, got.chunk_done,
                           want.chunk_done));
        if (got.stream_done !== want.stream_done)
          report($sformatf("tag %0d stream_done %b, want %b", checked, got.stream_done,
                           want.stream_done));
        if (got.sig_error !== want.sig_error)
          report($sformatf("tag %0d sig_error %b, want %b", checked, got.sig_error,
                           want.sig_error));
        if (got.last !== want.last)
          report($sformatf("tag %0d last %b, want %b", checked, got.last, want.last));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'd0;
  logic       inject_enable_we = 1'b0;
  logic       inject_enable = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] byte_role;
  logic       text_data;
  logic       chunk_done;
  logic       stream_done;
  logic       sig_error;
  logic       last;

  png_tag_scoreboard sb;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int bytes_sent = 0;
  int chunks_sent = 0;

  png_chunk_stream_parser dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .inject_enable_we(inject_enable_we),
    .inject_enable(inject_enable),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .byte_role(byte_role),
    .text_data(text_data),
    .chunk_done(chunk_done),
    .stream_done(stream_done),
    .sig_error(sig_error),
    .last(last)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 18) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] random_chunk_type();
    logic [31:0] w;
    case ($urandom_range(0, 8))
      0, 1: w = TYPE_IHDR;
      2: w = TYPE_TEXT;
      3: w = TYPE_HIVE;
      4: w = TYPE_IDAT;
      5: w = TYPE_PLTE;
      6: begin
        w = $urandom();
        if (w == TYPE_IEND) w = TYPE_IDAT;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: w = TYPE_IEND;
          1: w = TYPE_IHDR;
          2: w = TYPE_TEXT;
          default: w = TYPE_HIVE;
        endcase
        w[$urandom_range(0, 31)] ^= 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic int unsigned pick_len();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return $urandom_range(256, 300);
    if (r < 8) return 0;
    if (r < 30) return $urandom_range(1, 8);
    return $urandom_range(9, 24);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = (send_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_byte = b;
    do @(posedge clk); while (full);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic drain_requests();
    @(negedge clk);
    push = 1'b0;
    while (sb.tags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_inject(input bit on);
    drain_requests();
    @(negedge clk);
    inject_enable_we = 1'b1;
    inject_enable = on;
    @(negedge clk);
    inject_enable_we = 1'b0;
    sb.inject_on = on;
  endtask

  task automatic send_chunk(input logic [31:0] type_word, input int unsigned len);
    logic [31:0] len_word;
    len_word = len;
    for (int i = 3; i >= 0; i--) push_byte(len_word[8 * i +: 8]);
    for (int i = 0; i < 4; i++) push_byte(type_word[8 * i +: 8]);
    for (int unsigned i = 0; i < len; i++) push_byte(rand_byte());
    repeat (4) push_byte(rand_byte());
    chunks_sent++;
  endtask

  initial begin
    int      stall;
    int      span;
    stall = 0;
    span = 0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (span == 0) begin
        recv_calm = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 200);
      end
      span--;
      if (stall > 0) begin
        pop = 1'b0;
        stall--;
      end else begin
        pop = 1'b1;
        if (!recv_calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    pngcp_res_t seen;
    if (!rst && pop === 1'b1 && empty === 1'b0) begin
      seen.data = out_byte;
      seen.role = byte_role;
      seen.text = text_data;
      seen.chunk_done = chunk_done;
      seen.stream_done = stream_done;
      seen.sig_error = sig_error;
      seen.last = last;
      sb.check_tag(seen);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for the parser");
    $display("status: fail");
    $finish;
  end

  initial begin
    bit          corrupt;
    int          bad_at;
    int          target;
    logic [7:0]  bad;
    sb = new();
    repeat (11) @(negedge clk);
    rst = 1'b0;

    corrupt = ($urandom_range(0, 5) == 0);
    set_inject(1'b1);
    if (corrupt) begin
      bad_at = $urandom_range(0, 7);
      for (int i = 0; i < bad_at; i++) push_byte(SIG_BYTES[i]);
      bad = rand_byte();
      if (bad == SIG_BYTES[bad_at]) bad = ~bad;
      push_byte(bad);
      for (int i = 0; i < 150; i++) begin
        if (i == 75) set_inject(1'b0);
        send_calm = (i % 40) < 10;
        push_byte(rand_byte());
      end
    end else begin
      for (int i = 0; i < 8; i++) push_byte(SIG_BYTES[i]);
      send_chunk(TYPE_IHDR, 0);
      set_inject(1'b0);
      target = bytes_sent + 150;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 4) == 0) set_inject(1'($urandom_range(0, 1)));
        send_calm = ($urandom_range(0, 3) == 0);
        send_chunk(random_chunk_type(), pick_len());
      end
      send_chunk(TYPE_IEND, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
      repeat ($urandom_range(4, 10)) push_byte(rand_byte());
    end

    drain_requests();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes in %0d chunks, %0d hiVe insertions, %0d tags checked",
             bytes_sent, chunks_sent, sb.insertions, sb.checked);
    $display("signature corrupted: %0d, mismatches: %0d", corrupt, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
